// ===== sv/pec_pkg.sv =====
// Package for the polynomial coefficient evaluator.
// Holds field widths, operation codes and accumulator limits.
// No dependencies.
package pec_pkg;

    // Default size of the coefficient table.
    localparam int DEF_MAX_TERMS = 16;

    // Field widths.
    localparam int IDX_IN_W = 5;
    localparam int COEF_W   = 32;
    localparam int VAL_W    = 48;
    localparam int DEG_W    = 4;

    // Operation codes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    // Q31.16 accumulator limits.
    localparam logic signed [VAL_W-1:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [VAL_W-1:0] ACC_MIN = 48'sh8000_0000_0000;

    // Magnitude bounds used when a product is clipped.
    localparam logic [63:0] MAG_POS_MAX = 64'h0000_7FFF_FFFF_FFFF;
    localparam logic [63:0] MAG_NEG_MAX = 64'h0000_8000_0000_0000;

endpackage

// ===== sv/polynomial_coefficient_evaluator.sv =====
// Polynomial coefficient evaluator: a write stores one Q15.16 coefficient, an evaluate
// runs Horner's rule over the terms in use with a saturating Q31.16 accumulator.
// A write that clears the top coefficient finds the degree again by a downward scan; an
// evaluate runs five steps per term (magnitude, low and high multiply, fix, accumulate)
// around one shared 32x32 multiplier. One item at a time. Synchronous active-low reset
// clears the table's nonzero flags (so every entry reads as zero), term count and degree.
module polynomial_coefficient_evaluator
    import pec_pkg::*;
#(
    parameter int MAX_TERMS = pec_pkg::DEF_MAX_TERMS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input channel.
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_operation,
    input  logic [pec_pkg::IDX_IN_W-1:0]        i_term_index,
    input  logic signed [pec_pkg::COEF_W-1:0]   i_coefficient,
    input  logic signed [pec_pkg::COEF_W-1:0]   i_point,
    // Output channel.
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [pec_pkg::VAL_W-1:0]    o_value,
    output logic [pec_pkg::DEG_W-1:0]           o_degree,
    output logic                                o_all_zero,
    output logic                                o_saturated,
    output logic                                o_index_error
);

    localparam int IDX_W = $clog2(MAX_TERMS);
    localparam int CNT_W = $clog2(MAX_TERMS + 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_MAG  = 3'd2;
    localparam logic [2:0] S_MLO  = 3'd3;
    localparam logic [2:0] S_MHI  = 3'd4;
    localparam logic [2:0] S_FIX  = 3'd5;
    localparam logic [2:0] S_ACC  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]              r_state;
    logic [MAX_TERMS-1:0]    r_nz;
    logic [CNT_W-1:0]        r_terms;
    logic [IDX_W-1:0]        r_degree;
    logic                    r_all_zero;
    logic [IDX_W-1:0]        r_idx;
    logic signed [VAL_W-1:0] r_acc;
    logic                    r_sat;
    logic                    r_ierr;
    logic                    r_xneg;
    logic [31:0]             r_xm;
    logic                    r_aneg;
    logic [VAL_W-1:0]        r_am;
    logic [63:0]             r_mul;
    logic [48:0]             r_lo_rnd;
    logic signed [VAL_W-1:0] r_prod;

    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_value;
    logic [DEG_W-1:0]        r_deg_out;
    logic                    r_zero_out;
    logic                    r_sat_out;
    logic                    r_ierr_out;

    logic                    accept;
    logic                    idx_bad;
    logic [IDX_W-1:0]        wr_idx;
    logic                    coef_nz;
    logic                    ram_we;
    logic [COEF_W-1:0]       ram_rdata;
    logic signed [COEF_W-1:0] coef;
    logic [31:0]             mul_a;
    logic [63:0]             mul_p;
    logic [63:0]             fix_mag;
    logic                    fix_neg;
    logic signed [VAL_W-1:0] n_prod;
    logic                    n_prod_sat;
    logic signed [VAL_W:0]   acc_sum;
    logic signed [VAL_W-1:0] n_acc;
    logic                    n_acc_sat;
    logic                    out_free;

    // Input transfer and write decode.
    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);
    assign idx_bad = (32'(i_term_index) >= 32'(MAX_TERMS));
    assign wr_idx  = IDX_W'(i_term_index);
    assign coef_nz = (i_coefficient != '0);
    assign ram_we  = accept && (i_operation == OP_WRITE) && !idx_bad;

    // Coefficient store; an entry never made nonzero reads as zero.
    pec_ram #(
        .WIDTH (COEF_W),
        .DEPTH (MAX_TERMS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_idx),
        .i_wdata (i_coefficient),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign coef = r_nz[r_idx] ? $signed(ram_rdata) : '0;

    // Shared multiplier: low 32 bits of the accumulator magnitude, then its high 16 bits.
    assign mul_a = (r_state == S_MLO) ? r_am[31:0] : {16'd0, r_am[47:32]};
    assign mul_p = 64'(mul_a) * 64'(r_xm);

    // Recombine the partial products, apply the sign and clip the product.
    always_comb begin
        fix_mag    = {r_mul[47:0], 16'd0} + 64'(r_lo_rnd);
        fix_neg    = r_aneg ^ r_xneg;
        n_prod_sat = 1'b0;
        if (fix_neg) begin
            if (fix_mag > MAG_NEG_MAX) begin
                n_prod     = ACC_MIN;
                n_prod_sat = 1'b1;
            end else begin
                n_prod = -$signed(fix_mag[VAL_W-1:0]);
            end
        end else begin
            if (fix_mag > MAG_POS_MAX) begin
                n_prod     = ACC_MAX;
                n_prod_sat = 1'b1;
            end else begin
                n_prod = $signed(fix_mag[VAL_W-1:0]);
            end
        end
    end

    // Add the coefficient and clip the accumulator.
    always_comb begin
        acc_sum   = {r_prod[VAL_W-1], r_prod} + (VAL_W+1)'(coef);
        n_acc_sat = (acc_sum[VAL_W] != acc_sum[VAL_W-1]);
        if (!n_acc_sat) begin
            n_acc = acc_sum[VAL_W-1:0];
        end else if (acc_sum[VAL_W]) begin
            n_acc = ACC_MIN;
        end else begin
            n_acc = ACC_MAX;
        end
    end

    assign out_free = !r_out_valid || !i_stall;

    // Control sequencer and table bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_nz       <= '0;
            r_terms    <= '0;
            r_degree   <= '0;
            r_all_zero <= 1'b1;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_operation == OP_WRITE)) begin
                        r_state <= S_DONE;
                        if (!idx_bad) begin
                            r_nz[wr_idx] <= coef_nz;
                            if (r_terms < CNT_W'(wr_idx) + CNT_W'(1)) begin
                                r_terms <= CNT_W'(wr_idx) + CNT_W'(1);
                            end
                            if (coef_nz) begin
                                if (r_all_zero || (wr_idx > r_degree)) begin
                                    r_degree   <= wr_idx;
                                    r_all_zero <= 1'b0;
                                end
                            end else if (!r_all_zero && (wr_idx == r_degree)) begin
                                // The top term was cleared: find the next one down.
                                if (wr_idx == '0) begin
                                    r_all_zero <= 1'b1;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                        end
                    end else if (accept) begin
                        r_state <= (r_terms == '0) ? S_DONE : S_MAG;
                    end
                end
                S_SCAN: begin
                    if (r_nz[r_idx]) begin
                        r_degree <= r_idx;
                        r_state  <= S_DONE;
                    end else if (r_idx == '0) begin
                        r_degree   <= '0;
                        r_all_zero <= 1'b1;
                        r_state    <= S_DONE;
                    end
                end
                S_MAG: r_state <= S_MLO;
                S_MLO: r_state <= S_MHI;
                S_MHI: r_state <= S_FIX;
                S_FIX: r_state <= S_ACC;
                S_ACC: r_state <= (r_idx == '0) ? S_DONE : S_MAG;
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers of the Horner loop and the scan counter.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_acc  <= '0;
                    r_sat  <= 1'b0;
                    r_ierr <= (i_operation == OP_WRITE) && idx_bad;
                    r_xneg <= i_point[COEF_W-1];
                    r_xm   <= i_point[COEF_W-1] ? 32'(-i_point) : 32'(i_point);
                    if (i_operation == OP_WRITE) begin
                        r_idx <= wr_idx - IDX_W'(1);
                    end else begin
                        r_idx <= IDX_W'(r_terms - CNT_W'(1));
                    end
                end
            end
            S_SCAN: begin
                r_idx <= r_idx - IDX_W'(1);
            end
            S_MAG: begin
                r_aneg <= r_acc[VAL_W-1];
                r_am   <= r_acc[VAL_W-1] ? VAL_W'(-r_acc) : VAL_W'(r_acc);
            end
            S_MLO: begin
                r_mul <= mul_p;
            end
            S_MHI: begin
                r_lo_rnd <= 49'((65'(r_mul) + 65'h8000) >> 16);
                r_mul    <= mul_p;
            end
            S_FIX: begin
                r_prod <= n_prod;
                r_sat  <= r_sat | n_prod_sat;
            end
            S_ACC: begin
                r_acc <= n_acc;
                r_sat <= r_sat | n_acc_sat;
                r_idx <= r_idx - IDX_W'(1);
            end
            default: begin
            end
        endcase
    end

    // Output register; it holds while the consumer stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_value    <= r_acc;
            r_deg_out  <= DEG_W'(r_degree);
            r_zero_out <= r_all_zero;
            r_sat_out  <= r_sat;
            r_ierr_out <= r_ierr;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_value       = r_value;
    assign o_degree      = r_deg_out;
    assign o_all_zero    = r_zero_out;
    assign o_saturated   = r_sat_out;
    assign o_index_error = r_ierr_out;

    // In idle, the degree register names a nonzero entry unless the table is all zero.
    a_degree_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_all_zero && r_state == S_IDLE) |-> r_nz[r_degree])
        else $error("degree does not point at a nonzero coefficient");

    // An all-zero table has no nonzero entries.
    a_all_zero_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_all_zero && r_state == S_IDLE) |-> (r_nz == '0))
        else $error("all-zero flag set while a coefficient is nonzero");

    // The term count never exceeds the table.
    a_terms_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_terms) <= 32'(MAX_TERMS))
        else $error("term count beyond table size");

    // A write with a bad index reports neither a value nor saturation.
    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_index_error) |-> (!o_saturated && o_value == '0))
        else $error("index error result carries evaluation data");

    // An evaluate over a nonempty table starts the Horner loop.
    a_eval_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_operation == OP_EVAL && r_terms != '0) |=> (r_state == S_MAG))
        else $error("evaluate did not start the Horner loop");

endmodule

// ===== sv/pec_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Width and depth are parameters. No dependencies.
module pec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
